// ===== design/fbtp_pkg.sv =====
package fbtp_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_BYTES  = 4;
    localparam int WORD_W      = BYTE_W * WORD_BYTES;
    localparam int RES_BYTES   = WORD_BYTES - 1;
    localparam int RES_W       = BYTE_W * RES_BYTES;
    localparam int ACC_W       = WORD_W + RES_W;
    localparam int KEEP_W      = 6;
    localparam int KEEP_MIN    = 1;
    localparam int KEEP_MAX    = 32;
    localparam int QUEUE_DEPTH = 3;

    typedef logic [2:0] byte_cnt_t;
    typedef logic [1:0] res_cnt_t;
    typedef logic [1:0] q_cnt_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } entry_t;

    typedef struct packed {
        logic [1:0] count;
        entry_t     first;
        entry_t     second;
    } push_t;

    function automatic byte_cnt_t keep_to_bytes(input logic [KEEP_W-1:0] keep);
        logic [KEEP_W:0] clamped;
        logic [KEEP_W:0] rounded;
        clamped = {1'b0, keep};
        if (keep < KEEP_W'(KEEP_MIN))
        begin
            clamped = (KEEP_W + 1)'(KEEP_MIN);
        end
        else if (keep > KEEP_W'(KEEP_MAX))
        begin
            clamped = (KEEP_W + 1)'(KEEP_MAX);
        end
        rounded = (clamped + (KEEP_W + 1)'(BYTE_W - 1)) >> 3;
        return rounded[2:0];
    endfunction

endpackage

// ===== design/fbtp_if.sv =====
interface fbtp_in_if;
    logic                       valid;
    logic                       ready;
    logic [fbtp_pkg::WORD_W-1:0] value;
    logic                       is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink (input valid, input value, input is_last, output ready);
endinterface

interface fbtp_out_if;
    logic                       valid;
    logic                       ready;
    logic [fbtp_pkg::WORD_W-1:0] packed_word;
    logic                       last_word;

    modport source (output valid, output packed_word, output last_word, input ready);
    modport sink (input valid, input packed_word, input last_word, output ready);
endinterface

// ===== design/float_byte_truncate_pack_top.sv =====
// Channel   Dir  Payload                         Handshake
// in_ch     in   value[31:0], is_last            valid/ready
// out_ch    out  packed_word[31:0], last_word    valid/ready
// cfg       in   cfg_wr_data[5:0] (keep_bits)    cfg_wr_en, no wait
//
// One request is taken per cycle while the three-entry result queue has room for its words.
// A request that yields two words waits until two entries are free.
// An accepted request is held in the input stage register, and its result words then pass
// through the queue registers to out_ch.
// Reset clears the residue, the input stage and the queue, and sets keep_bits to 32.
// A stall on the output fills the queue and then lowers in_ch.ready.
module float_byte_truncate_pack_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fbtp_pkg::KEEP_W-1:0]   cfg_wr_data,
    fbtp_in_if.sink                       in_ch,
    fbtp_out_if.source                    out_ch
);

    fbtp_pkg::push_t  push;
    fbtp_pkg::q_cnt_t free_slots;

    fbtp_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .free_slots  (free_slots),
        .push        (push)
    );

    fbtp_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free_slots (free_slots),
        .out_ch     (out_ch)
    );

endmodule

// ===== design/fbtp_pack.sv =====
module fbtp_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fbtp_pkg::KEEP_W-1:0]   cfg_wr_data,
    fbtp_in_if.sink                       in_ch,
    input  fbtp_pkg::q_cnt_t              free_slots,
    output fbtp_pkg::push_t               push
);

    fbtp_pkg::byte_cnt_t               k_reg;
    logic                              item_valid_reg;
    logic [fbtp_pkg::WORD_W-1:0]       value_reg;
    logic                              last_reg;
    logic [fbtp_pkg::RES_W-1:0]        residue_reg;
    logic [fbtp_pkg::RES_W-1:0]        residue_next;
    fbtp_pkg::res_cnt_t                res_cnt_reg;
    fbtp_pkg::res_cnt_t                res_cnt_next;

    logic [fbtp_pkg::WORD_W-1:0]       kept;
    logic [fbtp_pkg::ACC_W-1:0]        acc;
    fbtp_pkg::byte_cnt_t               total;
    logic                              full;
    fbtp_pkg::res_cnt_t                rem_cnt;
    logic [fbtp_pkg::RES_W-1:0]        rem_bytes;
    fbtp_pkg::push_t                   words;
    logic                              fire;

    always_comb
    begin
        unique case (k_reg)
            3'd1:    kept = {24'b0, value_reg[31:24]};
            3'd2:    kept = {16'b0, value_reg[31:16]};
            3'd3:    kept = {8'b0, value_reg[31:8]};
            default: kept = value_reg;
        endcase

        acc = fbtp_pkg::ACC_W'(residue_reg)
            | (fbtp_pkg::ACC_W'(kept) << {res_cnt_reg, 3'b000});
        total = {1'b0, res_cnt_reg} + k_reg;
        full = total[2];
        rem_cnt = total[1:0];
        rem_bytes = full ? acc[fbtp_pkg::ACC_W-1:fbtp_pkg::WORD_W]
                         : acc[fbtp_pkg::RES_W-1:0];

        words.first.word = acc[fbtp_pkg::WORD_W-1:0];
        words.first.last = last_reg && (rem_cnt == 2'd0);
        words.second.word = {8'b0, rem_bytes};
        words.second.last = 1'b1;
        words.count = 2'd0;
        if (full)
        begin
            words.count = (last_reg && (rem_cnt != 2'd0)) ? 2'd2 : 2'd1;
        end
        else
        begin
            words.first = words.second;
            words.count = last_reg ? 2'd1 : 2'd0;
        end

        fire = item_valid_reg && (words.count <= free_slots);

        push = words;
        if (!fire)
        begin
            push.count = 2'd0;
        end

        residue_next = rem_bytes;
        res_cnt_next = rem_cnt;
        if (last_reg)
        begin
            residue_next = '0;
            res_cnt_next = 2'd0;
        end
    end

    assign in_ch.ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg          <= 3'd4;
            item_valid_reg <= 1'b0;
            residue_reg    <= '0;
            res_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                k_reg <= fbtp_pkg::keep_to_bytes(cfg_wr_data);
            end
            if (in_ch.ready)
            begin
                item_valid_reg <= in_ch.valid;
            end
            if (fire)
            begin
                residue_reg <= residue_next;
                res_cnt_reg <= res_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            value_reg <= in_ch.value;
            last_reg  <= in_ch.is_last;
        end
    end

endmodule

// ===== design/fbtp_out_queue.sv =====
module fbtp_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  fbtp_pkg::push_t    push,
    output fbtp_pkg::q_cnt_t   free_slots,
    fbtp_out_if.source         out_ch
);

    fbtp_pkg::entry_t slot_reg [fbtp_pkg::QUEUE_DEPTH];
    fbtp_pkg::entry_t slot_next [fbtp_pkg::QUEUE_DEPTH];
    fbtp_pkg::q_cnt_t count_reg;
    fbtp_pkg::q_cnt_t count_next;
    logic             pop;
    logic [2:0]       base;

    assign pop = (count_reg != 2'd0) && out_ch.ready;
    assign free_slots = 2'(fbtp_pkg::QUEUE_DEPTH) - count_reg;
    assign out_ch.valid = (count_reg != 2'd0);
    assign out_ch.packed_word = slot_reg[0].word;
    assign out_ch.last_word = slot_reg[0].last;

    always_comb
    begin
        base = {1'b0, count_reg} - {2'b0, pop};
        for (int i = 0; i < fbtp_pkg::QUEUE_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (pop && (i < fbtp_pkg::QUEUE_DEPTH - 1))
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            if ((push.count != 2'd0) && (3'(i) == base))
            begin
                slot_next[i] = push.first;
            end
            if ((push.count == 2'd2) && (3'(i) == base + 3'd1))
            begin
                slot_next[i] = push.second;
            end
        end
        count_next = 2'(base + {1'b0, push.count});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < fbtp_pkg::QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule
